@@ src/trt_pkg.sv @@
`timescale 1ns / 1ps

package trt_pkg;

  localparam int unsigned MAP_AW    = 16;
  localparam int unsigned DEFORM_AW = 8;
  localparam int unsigned OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_PIXEL     = 2'd0,
    CMD_MAP_WR    = 2'd1,
    CMD_DEFORM_WR = 2'd2
  } cmd_t;

  localparam logic REG_SCROLL_X = 1'b0;
  localparam logic REG_SCROLL_Y = 1'b1;

  // One item on its way from the deform lookup to the texture access.
  typedef struct packed {
    logic        pix;
    logic        map_we;
    logic [15:0] word;
    logic [7:0]  img;
    logic [15:0] widx;
    logic [7:0]  wbyte;
  } s1_t;

endpackage

@@ src/trt_deform.sv @@
`timescale 1ns / 1ps

module trt_deform (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [1:0]      cmd,
  input  logic [15:0]     lookup_word,
  input  logic [7:0]      image_pixel,
  input  logic [15:0]     write_index,
  input  logic [15:0]     write_value,
  output trt_pkg::s1_t    s1,
  output logic [15:0]     deform_rd
);
  import trt_pkg::*;

  logic [15:0] deform_mem [0:(1 << DEFORM_AW) - 1];
  logic        is_pix;
  logic        is_map;
  logic        is_def;

  always_comb begin
    is_pix = 1'b0;
    is_map = 1'b0;
    is_def = 1'b0;
    unique case (cmd)
      CMD_PIXEL:     is_pix = 1'b1;
      CMD_MAP_WR:    is_map = 1'b1;
      CMD_DEFORM_WR: is_def = 1'b1;
      default:       ;
    endcase
  end

  // In-range writes land at the accepting edge, so a later pixel always sees them.
  always_ff @(posedge clk) begin
    if (fire && is_def && (write_index[15:DEFORM_AW] == '0)) begin
      deform_mem[write_index[DEFORM_AW-1:0]] <= write_value;
    end
    deform_rd <= deform_mem[lookup_word[15:8]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.pix    <= 1'b0;
      s1.map_we <= 1'b0;
    end else begin
      s1.pix    <= fire && is_pix;
      s1.map_we <= fire && is_map;
    end
    s1.word  <= lookup_word;
    s1.img   <= image_pixel;
    s1.widx  <= write_index;
    s1.wbyte <= write_value[7:0];
  end

endmodule

@@ src/trt_texture.sv @@
`timescale 1ns / 1ps

module trt_texture (
  input  logic         clk,
  input  logic         rst,
  input  trt_pkg::s1_t s1,
  input  logic [15:0]  deform_rd,
  input  logic [7:0]   scroll_x,
  input  logic [7:0]   scroll_y,
  output logic         s2_pix,
  output logic [7:0]   pix_data
);
  import trt_pkg::*;

  logic [7:0]  tex_mem [0:(1 << MAP_AW) - 1];
  logic [15:0] tex_addr;
  logic [7:0]  tex_rd;
  logic [7:0]  s2_img;

  assign tex_addr = s1.word + {scroll_x, scroll_y} + deform_rd;

  // Map writes and pixel reads both pass through here in item order.
  always_ff @(posedge clk) begin
    if (s1.map_we) begin
      tex_mem[s1.widx] <= s1.wbyte;
    end
    tex_rd <= tex_mem[tex_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_pix <= 1'b0;
    end else begin
      s2_pix <= s1.pix;
    end
    s2_img <= s1.img;
  end

  assign pix_data = s2_img + tex_rd;

endmodule

@@ src/trt_out_fifo.sv @@
`timescale 1ns / 1ps

module trt_out_fifo (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_data,
  input  logic       pop,
  output logic       not_empty,
  output logic [7:0] head,
  output logic [$clog2(trt_pkg::OUT_DEPTH):0] count
);
  import trt_pkg::*;

  localparam int unsigned PW = $clog2(OUT_DEPTH);

  logic [7:0]  buf_mem [0:OUT_DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count_next;

  assign not_empty = (count != '0);
  assign head      = buf_mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ src/tunnel_texture_remap.sv @@
`timescale 1ns / 1ps

// Tunnel texture remapper.
// Input channel (in_valid/in_ready) carries one command per beat: a pixel,
// a texture map byte write or a deform table entry write. Output channel
// (out_valid/out_ready) returns one pixel_out beat per pixel command; write
// commands return nothing. Scroll registers are set by the user through
// cfg_we, cfg_index and cfg_data while the block is idle; it does not enforce this.
// A pixel beat reads the deform table in the cycle it is accepted, then the
// texture map in the next cycle, and its result enters a four-entry output
// buffer, which raises out_valid once it holds an entry.
// Throughput is one beat per clock while in_ready is high; each of the two
// synchronous memories can take a write and a read in the same cycle.
// When the receiver stalls, results collect in the output buffer; in_ready
// drops only once buffered plus in-flight pixels would fill it, so results
// are never lost. Reset clears the scroll registers, the pipeline valids
// and the buffer; the texture map and deform table keep no reset value and
// must be loaded before pixels use them.
module tunnel_texture_remap (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [15:0] lookup_word,
  input  logic [7:0]  image_pixel,
  input  logic [15:0] write_index,
  input  logic [15:0] write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_out,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import trt_pkg::*;

  localparam int unsigned CW = $clog2(OUT_DEPTH) + 1;

  logic [7:0]  scroll_x;
  logic [7:0]  scroll_y;
  logic        fire;
  s1_t         s1;
  logic [15:0] deform_rd;
  logic        s2_pix;
  logic [7:0]  pix_data;
  logic [CW-1:0] fifo_count;
  logic [CW:0]   pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x <= '0;
      scroll_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCROLL_X: scroll_x <= cfg_data;
        REG_SCROLL_Y: scroll_y <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Count every result that will land in the buffer, not just those there.
  assign pending  = {1'b0, fifo_count} + (CW+1)'(s1.pix) + (CW+1)'(s2_pix);
  assign in_ready = (pending < (CW+1)'(OUT_DEPTH));
  assign fire     = in_valid && in_ready;

  trt_deform u_deform (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .cmd         (cmd),
    .lookup_word (lookup_word),
    .image_pixel (image_pixel),
    .write_index (write_index),
    .write_value (write_value),
    .s1          (s1),
    .deform_rd   (deform_rd)
  );

  trt_texture u_texture (
    .clk       (clk),
    .rst       (rst),
    .s1        (s1),
    .deform_rd (deform_rd),
    .scroll_x  (scroll_x),
    .scroll_y  (scroll_y),
    .s2_pix    (s2_pix),
    .pix_data  (pix_data)
  );

  trt_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_pix),
    .push_data (pix_data),
    .pop       (out_valid && out_ready),
    .not_empty (out_valid),
    .head      (pixel_out),
    .count     (fifo_count)
  );

endmodule
